### rtl/core/battery_level_monitor_unit_macros.svh
// ----------------------------------------------------------------------------
// battery level monitor assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BLM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("battery level monitor check failed");
// next-cycle implication
`define BLM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("battery level monitor check failed");
`else
`define BLM_ASSERT_IMP(lbl, ante, cons)
`define BLM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// shared constants, types and helpers of the battery level monitor
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

    // averaging ring
    localparam int AVG_DEPTH  = 6;
    localparam int SLOT_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W      = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W      = $clog2(AVG_DEPTH * 100 + 1);

    // field widths
    localparam int RAW_W      = 12;
    localparam int LVL_W      = 7;
    localparam int TICK_W     = 16;

    // shared divider: mapped numerator / half span, and ring sum / count
    localparam int DIVD_W     = 18;
    localparam int DIVS_W     = 11;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAW_W-1:0]  FLOOR_RST   = 12'd2720;
    localparam logic [RAW_W-1:0]  CEIL_RST    = 12'd3418;
    localparam logic [LVL_W-1:0]  THR_RST     = 7'd5;
    localparam logic [LVL_W-1:0]  HYST_RST    = 7'd2;
    localparam logic [TICK_W-1:0] WTICKS_RST  = 16'd1000;

    localparam logic [LVL_W-1:0]  LVL_MIN     = 7'd1;
    localparam logic [LVL_W-1:0]  LVL_MAX     = 7'd100;
    localparam logic [LVL_W-1:0]  MAP_SCALE   = 7'd99;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_RESTART = 2'd3
    } blm_kind_t;

    typedef enum logic [1:0] {
        EV_CHANGED   = 2'd0,
        EV_LOW       = 2'd1,
        EV_OK        = 2'd2,
        EV_POWER_OFF = 2'd3
    } blm_event_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FLOOR  = 3'd0,
        REG_CEIL   = 3'd1,
        REG_THR    = 3'd2,
        REG_HYST   = 3'd3,
        REG_WTICKS = 3'd4
    } blm_reg_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic map_load;
        logic div_start;
        logic div_sel_avg;
        logic push;
        logic eval;
        logic pwr_check;
        logic emit;
    } blm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       div_busy;
        logic [1:0] ev_n;
        logic       emit_last;
        logic       out_free;
    } blm_stat_t;

    // (level-1)/10 via reciprocal 205/2048, exact for levels up to 100
    function automatic logic [3:0] coarse_ten_f(input logic [LVL_W-1:0] lvl);
        logic [14:0] prod;
        begin
            prod = 15'(lvl - LVL_MIN) * 15'd205;
            coarse_ten_f = (lvl == '0) ? 4'd0 : prod[14:11];
        end
    endfunction

    // (level-1)/20+1 via reciprocal 205/4096
    function automatic logic [2:0] coarse_five_f(input logic [LVL_W-1:0] lvl);
        logic [14:0] prod;
        begin
            prod = 15'(lvl - LVL_MIN) * 15'd205;
            coarse_five_f = (lvl == '0) ? 3'd0 : 3'(prod[14:12] + 3'd1);
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/blm_div.sv
// ----------------------------------------------------------------------------
// blm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module blm_div import blm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   busy,
    output logic [DIVD_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVS_W-1:0]    dsr_reg, dsr_next;
    logic [DIVS_W:0]      trial;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DIVS_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = DIV_CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/blm_dp.sv
// ----------------------------------------------------------------------------
// blm_dp
// datapath: config registers, level mapping, averaging ring, low flag,
// warning countdown, event list and output register
// ----------------------------------------------------------------------------
`default_nettype none

module blm_dp import blm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire blm_cmd_t              cmd,
    output blm_stat_t                  stat,
    input  wire blm_kind_t             in_kind,
    input  wire logic [RAW_W-1:0]      in_raw,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output blm_event_t                 out_event,
    output logic [LVL_W-1:0]           out_level,
    output logic                       out_is_low,
    output logic [3:0]                 out_coarse_ten,
    output logic [2:0]                 out_coarse_five,
    output logic                       out_last
);

    // configuration
    logic [RAW_W-1:0]  floor_reg, floor_next;
    logic [RAW_W-1:0]  ceil_reg, ceil_next;
    logic [LVL_W-1:0]  thr_reg, thr_next;
    logic [LVL_W-1:0]  hyst_reg, hyst_next;
    logic [TICK_W-1:0] wticks_reg, wticks_next;

    // item and mapping
    blm_kind_t         kind_reg, kind_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [DIVD_W-1:0] num_reg, num_next;
    logic [DIVS_W-1:0] span_reg, span_next;
    logic              fix_reg, fix_next;
    logic [LVL_W-1:0]  fix_lvl_reg, fix_lvl_next;

    // averaging ring
    logic [LVL_W-1:0]  ring_reg [AVG_DEPTH];
    logic [LVL_W-1:0]  ring_next [AVG_DEPTH];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              clr_pend_reg, clr_pend_next;

    // level, low flag, countdown
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic              low_reg, low_next;
    logic [TICK_W-1:0] wcnt_reg, wcnt_next;
    logic              wrun_reg, wrun_next;
    logic              wexp_reg, wexp_next;

    // pending events
    blm_event_t        ev0_reg, ev0_next;
    blm_event_t        ev1_reg, ev1_next;
    logic [1:0]        evn_reg, evn_next;
    logic              evidx_reg, evidx_next;

    // output register
    logic              ov_reg, ov_next;
    blm_event_t        oev_reg, oev_next;
    logic [LVL_W-1:0]  olvl_reg, olvl_next;
    logic              olow_reg, olow_next;
    logic [3:0]        oten_reg, oten_next;
    logic [2:0]        ofive_reg, ofive_next;
    logic              olast_reg, olast_next;

    // divider
    logic              div_busy;
    logic [DIVD_W-1:0] div_q;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;

    logic [RAW_W-1:0]  diff;
    logic [RAW_W-1:0]  span_full;
    logic              narrow;
    logic [LVL_W-1:0]  push_lvl;
    logic [LVL_W-1:0]  avg;
    logic [LVL_W:0]    low_bound;
    logic              new_low;
    logic              emit_last;

    assign div_dividend = cmd.div_sel_avg ? DIVD_W'(sum_reg) : num_reg;
    assign div_divisor  = cmd.div_sel_avg ? DIVS_W'(cnt_reg) : span_reg;

    blm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign diff      = RAW_W'(raw_reg - floor_reg);
    assign span_full = RAW_W'(ceil_reg - floor_reg);
    assign narrow    = ({1'b0, ceil_reg} < ({1'b0, floor_reg} + 13'd2));
    assign push_lvl  = fix_reg ? fix_lvl_reg :
                       (div_q >= DIVD_W'(LVL_MAX)) ? LVL_MAX :
                       LVL_W'(div_q[LVL_W-1:0] + LVL_MIN);
    assign avg       = div_q[LVL_W-1:0];
    assign low_bound = {1'b0, thr_reg} + (low_reg ? {1'b0, hyst_reg} : '0);
    assign new_low   = ({1'b0, avg} < low_bound);
    assign emit_last = (2'({1'b0, evidx_reg} + 2'd1) == evn_reg);

    always_comb begin
        floor_next    = floor_reg;
        ceil_next     = ceil_reg;
        thr_next      = thr_reg;
        hyst_next     = hyst_reg;
        wticks_next   = wticks_reg;
        kind_next     = kind_reg;
        raw_next      = raw_reg;
        num_next      = num_reg;
        span_next     = span_reg;
        fix_next      = fix_reg;
        fix_lvl_next  = fix_lvl_reg;
        ring_next     = ring_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        clr_pend_next = clr_pend_reg;
        cur_next      = cur_reg;
        low_next      = low_reg;
        wcnt_next     = wcnt_reg;
        wrun_next     = wrun_reg;
        wexp_next     = wexp_reg;
        ev0_next      = ev0_reg;
        ev1_next      = ev1_reg;
        evn_next      = evn_reg;
        evidx_next    = evidx_reg;
        ov_next       = ov_reg && !out_ready;
        oev_next      = oev_reg;
        olvl_next     = olvl_reg;
        olow_next     = olow_reg;
        oten_next     = oten_reg;
        ofive_next    = ofive_reg;
        olast_next    = olast_reg;

        // config writes, indexes beyond the list are dropped
        if (cfg_we) begin
            case (cfg_addr)
                REG_FLOOR:  floor_next  = cfg_wdata[RAW_W-1:0];
                REG_CEIL:   ceil_next   = cfg_wdata[RAW_W-1:0];
                REG_THR:    thr_next    = cfg_wdata[LVL_W-1:0];
                REG_HYST:   hyst_next   = cfg_wdata[LVL_W-1:0];
                REG_WTICKS: wticks_next = cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end

        if (cmd.accept) begin
            kind_next  = in_kind;
            raw_next   = in_raw;
            evn_next   = '0;
            evidx_next = 1'b0;
            // pending clear empties the ring ahead of this sample
            if (in_kind == KIND_SAMPLE && clr_pend_reg) begin
                clr_pend_next = 1'b0;
                slot_next     = '0;
                cnt_next      = '0;
                sum_next      = '0;
                for (int i = 0; i < AVG_DEPTH; i++) begin
                    ring_next[i] = '0;
                end
            end
        end

        if (cmd.map_load) begin
            num_next     = DIVD_W'(diff[RAW_W-1:1]) * DIVD_W'(MAP_SCALE);
            span_next    = span_full[RAW_W-1:1];
            fix_next     = (raw_reg <= floor_reg) || narrow;
            fix_lvl_next = (raw_reg <= floor_reg) ? LVL_MIN : LVL_MAX;
        end

        if (cmd.push) begin
            ring_next[slot_reg] = push_lvl;
            sum_next = SUM_W'(sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(push_lvl));
            slot_next = (slot_reg == SLOT_W'(AVG_DEPTH - 1)) ? '0 :
                        SLOT_W'(slot_reg + 1'b1);
            if (cnt_reg < CNT_W'(AVG_DEPTH)) begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
        end

        if (cmd.eval) begin
            case (kind_reg)
                KIND_SAMPLE: begin
                    if (avg != cur_reg) begin
                        cur_next = avg;
                        low_next = new_low;
                        ev0_next = EV_CHANGED;
                        evn_next = 2'd1;
                        if (new_low != low_reg) begin
                            evn_next  = 2'd2;
                            wexp_next = 1'b0;
                            if (new_low) begin
                                ev1_next  = EV_LOW;
                                wcnt_next = wticks_reg;
                                wrun_next = 1'b1;
                            end else begin
                                ev1_next  = EV_OK;
                                wcnt_next = '0;
                                wrun_next = 1'b0;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (wrun_reg) begin
                        if (wcnt_reg <= TICK_W'(1)) begin
                            wcnt_next = '0;
                            wrun_next = 1'b0;
                            wexp_next = 1'b1;
                        end else begin
                            wcnt_next = TICK_W'(wcnt_reg - 1'b1);
                        end
                    end
                end
                KIND_CLEAR: begin
                    clr_pend_next = 1'b1;
                end
                KIND_RESTART: begin
                    evn_next  = 2'd1;
                    wexp_next = 1'b0;
                    if (low_reg) begin
                        ev0_next  = EV_LOW;
                        wcnt_next = wticks_reg;
                        wrun_next = 1'b1;
                    end else begin
                        ev0_next  = EV_OK;
                        wcnt_next = '0;
                        wrun_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // power off once the countdown has run out at the lowest level
        if (cmd.pwr_check) begin
            if (evn_reg != 2'd2 && cur_reg == LVL_MIN && wexp_reg) begin
                wcnt_next = '0;
                wrun_next = 1'b0;
                wexp_next = 1'b0;
                if (evn_reg == 2'd0) begin
                    ev0_next = EV_POWER_OFF;
                end else begin
                    ev1_next = EV_POWER_OFF;
                end
                evn_next = 2'(evn_reg + 2'd1);
            end
        end

        if (cmd.emit) begin
            ov_next    = 1'b1;
            oev_next   = evidx_reg ? ev1_reg : ev0_reg;
            olvl_next  = cur_reg;
            olow_next  = low_reg;
            oten_next  = coarse_ten_f(cur_reg);
            ofive_next = coarse_five_f(cur_reg);
            olast_next = emit_last;
            evidx_next = ~evidx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg    <= FLOOR_RST;
            ceil_reg     <= CEIL_RST;
            thr_reg      <= THR_RST;
            hyst_reg     <= HYST_RST;
            wticks_reg   <= WTICKS_RST;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg     <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            clr_pend_reg <= 1'b0;
            cur_reg      <= '0;
            low_reg      <= 1'b0;
            wcnt_reg     <= '0;
            wrun_reg     <= 1'b0;
            wexp_reg     <= 1'b0;
            evn_reg      <= '0;
            evidx_reg    <= 1'b0;
            ov_reg       <= 1'b0;
        end else begin
            floor_reg    <= floor_next;
            ceil_reg     <= ceil_next;
            thr_reg      <= thr_next;
            hyst_reg     <= hyst_next;
            wticks_reg   <= wticks_next;
            ring_reg     <= ring_next;
            slot_reg     <= slot_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            clr_pend_reg <= clr_pend_next;
            cur_reg      <= cur_next;
            low_reg      <= low_next;
            wcnt_reg     <= wcnt_next;
            wrun_reg     <= wrun_next;
            wexp_reg     <= wexp_next;
            evn_reg      <= evn_next;
            evidx_reg    <= evidx_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        raw_reg     <= raw_next;
        num_reg     <= num_next;
        span_reg    <= span_next;
        fix_reg     <= fix_next;
        fix_lvl_reg <= fix_lvl_next;
        ev0_reg     <= ev0_next;
        ev1_reg     <= ev1_next;
        oev_reg     <= oev_next;
        olvl_reg    <= olvl_next;
        olow_reg    <= olow_next;
        oten_reg    <= oten_next;
        ofive_reg   <= ofive_next;
        olast_reg   <= olast_next;
    end

    assign stat.div_busy  = div_busy;
    assign stat.ev_n      = evn_reg;
    assign stat.emit_last = emit_last;
    assign stat.out_free  = !ov_reg || out_ready;

    assign out_valid       = ov_reg;
    assign out_event       = oev_reg;
    assign out_level       = olvl_reg;
    assign out_is_low      = olow_reg;
    assign out_coarse_ten  = oten_reg;
    assign out_coarse_five = ofive_reg;
    assign out_last        = olast_reg;

endmodule

`default_nettype wire

### rtl/core/blm_ctrl.sv
// ----------------------------------------------------------------------------
// blm_ctrl
// sequencing state machine of the battery level monitor
// ----------------------------------------------------------------------------
`default_nettype none

module blm_ctrl import blm_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire blm_kind_t in_kind,
    output logic           in_ready,
    input  wire blm_stat_t stat,
    output blm_cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MAP   = 10'b00_0000_0010,
        S_DIVA  = 10'b00_0000_0100,
        S_WAITA = 10'b00_0000_1000,
        S_PUSH  = 10'b00_0001_0000,
        S_DIVB  = 10'b00_0010_0000,
        S_WAITB = 10'b00_0100_0000,
        S_EVAL  = 10'b00_1000_0000,
        S_PWR   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } blm_state_t;

    blm_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (in_kind == KIND_SAMPLE) ? S_MAP : S_EVAL;
                end
            end
            S_MAP: begin
                cmd.map_load = 1'b1;
                state_next   = S_DIVA;
            end
            S_DIVA: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAITA;
            end
            S_WAITA: begin
                if (!stat.div_busy) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = S_DIVB;
            end
            S_DIVB: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_avg = 1'b1;
                state_next      = S_WAITB;
            end
            S_WAITB: begin
                if (!stat.div_busy) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_PWR;
            end
            S_PWR: begin
                cmd.pwr_check = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (stat.ev_n == 2'd0) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### rtl/core/battery_level_monitor_unit.sv
// ----------------------------------------------------------------------------
// battery_level_monitor_unit
// averaged battery level with low warning, countdown and power-off events
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one item per request: kind in s_tuser (sample, 10 ms
//   tick, clear averaging store, restart low handling), raw adc reading in
//   s_tdata. each item yields zero, one or two result requests on the m_
//   channel: event code in m_tuser, level/low flag/coarse levels in m_tdata,
//   m_tlast on the final result of the item.
//   a sample runs map, divide, ring push, average divide, evaluate and power
//   check; a tick, clear or restart runs only evaluate and power check. the
//   two passes of the shared bit-serial divider set the sample time. s_tready
//   returns high as the last result is loaded, or once the sequencer finds
//   that the item has no result to load.
//   one item is worked on at a time; the output register lets the next item
//   be accepted while the last result still waits.
//   if the receiver stalls, results hold in the output register and the
//   sequencer waits before loading a second result.
//   reset (aresetn low, synchronous) restores register defaults, empties the
//   averaging ring, sets level to unknown and clears low flag and countdown.
//   config writes (cfg_we) take effect at once; user makes them while idle, unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_level_monitor_unit_macros.svh"

module battery_level_monitor_unit import blm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // [11:0] raw_reading, [15:12] zero
    input  wire logic [1:0]            s_tuser,  // [1:0] kind
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,  // [6:0] level, [7] is_low,
                                                 // [11:8] coarse_ten,
                                                 // [14:12] coarse_five, [15] zero
    output logic [1:0]                 m_tuser,  // [1:0] event_res
    output logic                       m_tlast,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    blm_cmd_t   cmd;
    blm_stat_t  stat;
    blm_event_t out_event;
    logic [LVL_W-1:0] out_level;
    logic             out_is_low;
    logic [3:0]       out_coarse_ten;
    logic [2:0]       out_coarse_five;

    // sequencer
    blm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (blm_kind_t'(s_tuser)),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // mapping, averaging, low flag and output register
    blm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_kind         (blm_kind_t'(s_tuser)),
        .in_raw          (s_tdata[RAW_W-1:0]),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_event       (out_event),
        .out_level       (out_level),
        .out_is_low      (out_is_low),
        .out_coarse_ten  (out_coarse_ten),
        .out_coarse_five (out_coarse_five),
        .out_last        (m_tlast)
    );

    assign m_tuser = out_event;
    assign m_tdata = {1'b0, out_coarse_five, out_coarse_ten, out_is_low, out_level};

    // an accepted item closes the input side in the following cycle
    `BLM_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // averaged level never leaves its range
    `BLM_ASSERT_IMP(a_level_range, m_tvalid, m_tdata[6:0] <= 7'd100)
    // low and ok events agree with the reported low flag
    `BLM_ASSERT_IMP(a_low_flag, m_tvalid && m_tuser == EV_LOW, m_tdata[7])
    `BLM_ASSERT_IMP(a_ok_flag, m_tvalid && m_tuser == EV_OK, !m_tdata[7])
    // power off only at the lowest level
    `BLM_ASSERT_IMP(a_pwr_level, m_tvalid && m_tuser == EV_POWER_OFF, m_tdata[6:0] == 7'd1)

endmodule

`default_nettype wire
